FILE: rtl/core/ptpd_pkg.sv
// Shared types and constants for the perspective-divide point transform.
`timescale 1ns / 1ps

package ptpd_pkg;

    localparam int unsigned FRAC_BITS_DEFAULT = 16;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned CFG_W      = 64;
    localparam int unsigned NUM_REGS   = 8;
    localparam int unsigned ADDR_W     = 6;
    localparam int unsigned NUM_LANES  = 3;
    localparam int unsigned NUM_ROWS   = 4;
    localparam int unsigned SUM_W      = 66;
    localparam int unsigned MAG_W      = SUM_W - 1;
    localparam int unsigned Q_W        = 32;
    localparam int unsigned REM_W      = MAG_W + Q_W;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = PTR_W + 1;

    localparam int unsigned REG_ROW0_C01 = 0;
    localparam int unsigned REG_ROW1_C01 = 2;
    localparam int unsigned REG_ROW2_C23 = 5;
    localparam int unsigned REG_ROW3_C23 = 7;

    localparam logic [Q_W-1:0] Q_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] Q_NEG_MAX = 32'h8000_0000;

    typedef logic [NUM_REGS-1:0][CFG_W-1:0] cfg_bank_t;

    // one classified point between the front end and the divider
    typedef struct packed {
        logic [NUM_LANES-1:0][REM_W-1:0] num;
        logic [MAG_W-1:0]                den;
        logic [NUM_LANES-1:0]            neg;
        logic [NUM_LANES-1:0]            ovf;
        logic                            wzero;
    } ptpd_entry_t;

endpackage

FILE: rtl/core/point_transform_perspective_divide.sv
// Top level: configuration registers, front end, queue and divider.
//
// Transforms (x, y, z, 1) by a 4x4 signed fixed-point matrix, then divides
// x, y and z by w with truncation toward zero and saturation.
// Input stream s_*: one point per word, s_tdata packs x, y, z.
// Output stream m_*: one result word per point, same order.
// Matrix: eight 64-bit registers on the APB port at 8*i, two
// coefficients each; write only while no word is in flight.
// Throughput: one word per cycle sustained while m_tready stays high.
// Path: three front stages, the queue, 32 divider stages of one
// quotient bit each, then one output register.
// When the receiver stalls, the divider holds; the front end keeps accepting
// until the four-entry queue and the last front stage are full, then s_tready drops.
// Reset clears all valid state and loads the identity matrix.
`timescale 1ns / 1ps

module point_transform_perspective_divide #(
    parameter int unsigned FRAC_BITS = ptpd_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ptpd_pkg::ADDR_W-1:0]  paddr,
    input  logic [ptpd_pkg::CFG_W-1:0]   pwdata,
    output logic [ptpd_pkg::CFG_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [95:0]                  s_tdata,  // point_x, point_y, point_z
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [95:0]                  m_tdata,  // proj_x, proj_y, proj_z
    output logic [1:0]                   m_tuser   // divide_error, saturated
);
    import ptpd_pkg::*;

    localparam logic [CFG_W-1:0] ONE_FX = CFG_W'(1) << FRAC_BITS;

    cfg_bank_t                       cfg_reg;
    logic [NUM_LANES-1:0][DATA_W-1:0] in_pt;
    logic [NUM_LANES-1:0][Q_W-1:0]   proj;
    ptpd_entry_t                     wr_entry, head;
    logic                            push, pop, full, empty;
    logic                            div_err, sat;

    assign pready = 1'b1;
    assign prdata = cfg_reg[paddr[5:3]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                if (i == REG_ROW0_C01 || i == REG_ROW2_C23)
                    cfg_reg[i] <= ONE_FX;
                else if (i == REG_ROW1_C01 || i == REG_ROW3_C23)
                    cfg_reg[i] <= ONE_FX << 32;
                else
                    cfg_reg[i] <= '0;
            end
        end
        else if (psel && penable && pwrite && pready)
            cfg_reg[paddr[5:3]] <= pwdata;
    end

    assign in_pt = s_tdata;

    ptpd_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_pt    (in_pt),
        .full     (full),
        .push     (push),
        .entry    (wr_entry)
    );

    ptpd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_entry),
        .pop     (pop),
        .rd_data (head),
        .full    (full),
        .empty   (empty)
    );

    ptpd_divider u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (empty),
        .pop         (pop),
        .head        (head),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_proj    (proj),
        .out_div_err (div_err),
        .out_sat     (sat)
    );

    assign m_tdata = proj;
    assign m_tuser = {sat, div_err};

endmodule

FILE: rtl/core/ptpd_front.sv
// Front end: matrix product, row sums, sign/magnitude split and overflow check.
`timescale 1ns / 1ps

module ptpd_front #(
    parameter int unsigned FRAC_BITS = ptpd_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  ptpd_pkg::cfg_bank_t                             cfg,
    input  logic                                            in_valid,
    output logic                                            in_ready,
    input  logic [ptpd_pkg::NUM_LANES-1:0][ptpd_pkg::DATA_W-1:0] in_pt,
    input  logic                                            full,
    output logic                                            push,
    output ptpd_pkg::ptpd_entry_t                           entry
);
    import ptpd_pkg::*;

    logic signed [63:0]       prod_reg [NUM_ROWS][NUM_LANES];
    logic signed [63:0]       prod_next [NUM_ROWS][NUM_LANES];
    logic signed [DATA_W-1:0] trans_reg [NUM_ROWS];
    logic signed [DATA_W-1:0] trans_next [NUM_ROWS];
    logic signed [SUM_W-1:0]  sum_reg [NUM_ROWS];
    logic signed [SUM_W-1:0]  sum_next [NUM_ROWS];
    ptpd_entry_t              entry_reg;
    ptpd_entry_t              entry_next;
    logic                     v1_reg, v2_reg, v3_reg;
    logic                     adv;

    assign adv      = !v3_reg || !full;
    assign in_ready = adv;
    assign push     = v3_reg && !full;
    assign entry    = entry_reg;

    always_comb
    begin
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            for (int c = 0; c < NUM_LANES; c++)
            begin
                a = cfg[2*r + (c >> 1)][32*(c & 1) +: 32];
                b = in_pt[c];
                prod_next[r][c] = a * b;
            end
            trans_next[r] = cfg[2*r + 1][63:32];
        end
    end

    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            sum_next[r] = SUM_W'(prod_reg[r][0]) + SUM_W'(prod_reg[r][1])
                        + SUM_W'(prod_reg[r][2]) + (SUM_W'(trans_reg[r]) <<< FRAC_BITS);
        end
    end

    always_comb
    begin
        logic [SUM_W-1:0] mag;
        logic [REM_W-1:0] den_sh;
        mag              = sum_reg[3][SUM_W-1] ? SUM_W'(-sum_reg[3]) : SUM_W'(sum_reg[3]);
        entry_next.den   = mag[MAG_W-1:0];
        entry_next.wzero = (sum_reg[3] == '0);
        den_sh           = {{(REM_W-MAG_W){1'b0}}, mag[MAG_W-1:0]} << Q_W;
        for (int k = 0; k < NUM_LANES; k++)
        begin
            mag = sum_reg[k][SUM_W-1] ? SUM_W'(-sum_reg[k]) : SUM_W'(sum_reg[k]);
            entry_next.num[k] = {{(REM_W-MAG_W){1'b0}}, mag[MAG_W-1:0]} << FRAC_BITS;
            entry_next.neg[k] = sum_reg[k][SUM_W-1] ^ sum_reg[3][SUM_W-1];
            entry_next.ovf[k] = (entry_next.num[k] >= den_sh);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg  <= prod_next;
            trans_reg <= trans_next;
            sum_reg   <= sum_next;
            entry_reg <= entry_next;
        end
    end

endmodule

FILE: rtl/core/ptpd_queue.sv
// Short queue between the front end and the divider.
`timescale 1ns / 1ps

module ptpd_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ptpd_pkg::ptpd_entry_t wr_data,
    input  logic                  pop,
    output ptpd_pkg::ptpd_entry_t rd_data,
    output logic                  full,
    output logic                  empty
);
    import ptpd_pkg::*;

    ptpd_entry_t      mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_data;
    end

`ifndef ASSERT_OFF
    a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("queue count above depth");
    a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");
    a_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue count did not advance");
`endif

endmodule

FILE: rtl/core/ptpd_divider.sv
// Back end: pipelined restoring divide, one quotient bit per stage, and result mapping.
`timescale 1ns / 1ps

module ptpd_divider (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             empty,
    output logic                                             pop,
    input  ptpd_pkg::ptpd_entry_t                            head,
    output logic                                             out_valid,
    input  logic                                             out_ready,
    output logic [ptpd_pkg::NUM_LANES-1:0][ptpd_pkg::Q_W-1:0] out_proj,
    output logic                                             out_div_err,
    output logic                                             out_sat
);
    import ptpd_pkg::*;

    logic [NUM_LANES-1:0][REM_W-1:0] rem_reg [Q_W];
    logic [NUM_LANES-1:0][Q_W-1:0]   q_reg   [Q_W];
    logic [MAG_W-1:0]                den_reg [Q_W];
    logic [NUM_LANES-1:0]            neg_reg [Q_W];
    logic [NUM_LANES-1:0]            ovf_reg [Q_W];
    logic [Q_W-1:0]                  wz_reg;
    logic [Q_W-1:0]                  vld_reg;

    logic [NUM_LANES-1:0][Q_W-1:0]   proj_reg, proj_next;
    logic                            de_reg, de_next;
    logic                            sat_reg, sat_next;
    logic                            ov_reg;
    logic                            adv;

    assign adv         = !ov_reg || out_ready;
    assign pop         = adv && !empty;
    assign out_valid   = ov_reg;
    assign out_proj    = proj_reg;
    assign out_div_err = de_reg;
    assign out_sat     = sat_reg;

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        logic [NUM_LANES-1:0][REM_W-1:0] rem_in;
        logic [NUM_LANES-1:0][Q_W-1:0]   q_in;
        logic [MAG_W-1:0]                den_in;
        logic [NUM_LANES-1:0]            neg_in, ovf_in;
        logic                            wz_in, vld_in;
        logic [REM_W-1:0]                dsh;
        logic [NUM_LANES-1:0][REM_W-1:0] rem_out;
        logic [NUM_LANES-1:0][Q_W-1:0]   q_out;

        if (k == 0)
        begin : g_first
            assign rem_in = head.num;
            assign q_in   = '0;
            assign den_in = head.den;
            assign neg_in = head.neg;
            assign ovf_in = head.ovf;
            assign wz_in  = head.wzero;
            assign vld_in = !empty;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign den_in = den_reg[k-1];
            assign neg_in = neg_reg[k-1];
            assign ovf_in = ovf_reg[k-1];
            assign wz_in  = wz_reg[k-1];
            assign vld_in = vld_reg[k-1];
        end

        assign dsh = {{(REM_W-MAG_W){1'b0}}, den_in} << (Q_W - 1 - k);

        always_comb
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                rem_out[l] = rem_in[l];
                q_out[l]   = q_in[l];
                if (rem_in[l] >= dsh)
                begin
                    rem_out[l]            = rem_in[l] - dsh;
                    q_out[l][Q_W - 1 - k] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (adv)
                vld_reg[k] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k] <= rem_out;
                q_reg[k]   <= q_out;
                den_reg[k] <= den_in;
                neg_reg[k] <= neg_in;
                ovf_reg[k] <= ovf_in;
                wz_reg[k]  <= wz_in;
            end
        end
    end

    always_comb
    begin
        logic [Q_W-1:0] q;
        sat_next = 1'b0;
        de_next  = wz_reg[Q_W-1];
        for (int l = 0; l < NUM_LANES; l++)
        begin
            q = q_reg[Q_W-1][l];
            if (wz_reg[Q_W-1])
                proj_next[l] = '0;
            else if (neg_reg[Q_W-1][l])
            begin
                if (ovf_reg[Q_W-1][l] || (q > Q_NEG_MAX))
                begin
                    proj_next[l] = Q_NEG_MAX;
                    sat_next     = 1'b1;
                end
                else
                    proj_next[l] = Q_W'(0) - q;
            end
            else
            begin
                if (ovf_reg[Q_W-1][l] || q[Q_W-1])
                begin
                    proj_next[l] = Q_POS_MAX;
                    sat_next     = 1'b1;
                end
                else
                    proj_next[l] = q;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (adv)
            ov_reg <= vld_reg[Q_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            proj_reg <= proj_next;
            de_reg   <= de_next;
            sat_reg  <= sat_next;
        end
    end

`ifndef ASSERT_OFF
    a_de_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_div_err) |-> (out_proj == '0 && !out_sat))
        else $error("divide error with nonzero result");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(vld_reg))
        else $error("divider moved while stalled");
    a_pop_vld: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> vld_reg[0])
        else $error("popped word lost at first stage");
`endif

endmodule
